>>> src/solve_3x3_system_cramer_core_defines.svh
// Assertion macros for the core of this block.
// Each takes a label, a clock, an active-low reset, an antecedent, a consequent and a message.
`ifndef SOLVE_3X3_SYSTEM_CRAMER_CORE_DEFINES_SVH
`define SOLVE_3X3_SYSTEM_CRAMER_CORE_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CCR_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CCR_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/ccr_pkg.sv
package ccr_pkg;

    // Depth of the queue between the determinant front end and the divider back end.
    localparam int QUEUE_DEPTH = 4;

    // Requests from the top level to the queue.
    typedef struct packed {
        logic push;
        logic pop;
    } ccr_q_ctrl_t;

    // Status from the queue to the top level.
    typedef struct packed {
        logic full;
        logic empty;
    } ccr_q_stat_t;

endpackage

>>> src/solve_3x3_system_cramer_core.sv
// Solves one 3x3 linear system A*x = b per transfer by Cramer's rule.
// Input channel s_*: one transfer carries A row-major and b, signed fixed point.
// Output channel m_*: one transfer per input with x, a singular flag (zero
// determinant, x forced to zero) and a saturated flag (some element clipped).
// Each quotient is (numerator << FRAC_BITS) / determinant, truncated toward zero.
// Throughput is one system per cycle unless the output stalls. Seven stages
// form the determinant and numerators, each result then passes through the
// queue, DATA_WIDTH + 2 divider stages follow (the first flags overflow,
// each later one produces one quotient bit) and the output register ends the pipe.
// A four-entry queue separates the determinant stages from the dividers,
// so the front end keeps accepting while the back end is held.
// While m_tvalid is high and m_tready low the divider pipe and output register
// hold; when the queue is full and the last front stage valid, s_tready drops.
// Reset (aresetn low, synchronous) empties every stage and the queue.
`include "solve_3x3_system_cramer_core_defines.svh"

module solve_3x3_system_cramer_core #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22, rhs_0, rhs_1, rhs_2
    input  logic [((12*DATA_WIDTH+7)/8)*8-1:0]       s_tdata,
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // solution_0, solution_1, solution_2, singular, saturated
    output logic [((3*DATA_WIDTH+2+7)/8)*8-1:0]      m_tdata
);
    import ccr_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int DW = 3*W + 3;
    localparam int NW = DW + FRAC_BITS;
    localparam int QW = DW + 3*NW + 4;
    localparam int NS = W + 2;
    localparam int OW = ((3*W + 2 + 7)/8)*8;

    logic              f_valid;
    logic [QW-1:0]     f_data;
    logic [QW-1:0]     q_data;
    ccr_q_ctrl_t       q_ctrl;
    ccr_q_stat_t       q_stat;
    logic              en_b;
    logic [NS-1:0]     vb_reg;
    logic [NS-1:0]     sg_reg;
    logic [W-1:0]      val [3];
    logic [2:0]        sat;
    logic              m_tvalid_reg;
    logic [OW-1:0]     m_tdata_reg;
    logic [OW-1:0]     m_tdata_next;

    // Front end: determinant and numerators.
    ccr_front #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_data  (s_tdata[12*W-1:0]),
        .out_valid(f_valid),
        .out_ready(!q_stat.full),
        .out_data (f_data)
    );

    // Queue between the two halves.
    assign en_b        = !m_tvalid_reg || m_tready;
    assign q_ctrl.push = f_valid && !q_stat.full;
    assign q_ctrl.pop  = en_b && !q_stat.empty;

    ccr_queue #(
        .WIDTH(QW)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .ctrl   (q_ctrl),
        .stat   (q_stat),
        .wr_data(f_data),
        .rd_data(q_data)
    );

    // Back end: one pipelined divider per solution element.
    for (genvar k = 0; k < 3; k++) begin : g_div
        ccr_div #(
            .DATA_WIDTH(DATA_WIDTH),
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .aclk     (aclk),
            .en       (en_b),
            .nmag_in  (q_data[DW + k*NW +: NW]),
            .dmag_in  (q_data[DW-1:0]),
            .neg_in   (q_data[DW + 3*NW + k]),
            .value_out(val[k]),
            .sat_out  (sat[k])
        );
    end

    // Valid bits follow the divider stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en_b) begin
            vb_reg       <= {vb_reg[NS-2:0], !q_stat.empty};
            m_tvalid_reg <= vb_reg[NS-1];
        end
    end

    // Singular systems report zeros and no saturation.
    always_comb begin
        if (sg_reg[NS-1]) begin
            m_tdata_next = OW'({1'b0, 1'b1, {(3*W){1'b0}}});
        end else begin
            m_tdata_next = OW'({|sat, 1'b0, val[2], val[1], val[0]});
        end
    end

    always_ff @(posedge aclk) begin
        if (en_b) begin
            sg_reg      <= {sg_reg[NS-2:0], q_data[QW-1]};
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks on the block's own logic.
    `CCR_ASSERT_SAME(a_no_overflow, aclk, aresetn, q_ctrl.push, !q_stat.full, "queue push while full")
    `CCR_ASSERT_SAME(a_singular_zero, aclk, aresetn, m_tvalid && m_tdata[3*W], m_tdata[3*W-1:0] == '0 && !m_tdata[3*W+1], "singular result not zero")
    `CCR_ASSERT_NEXT(a_result_out, aclk, aresetn, vb_reg[NS-1] && en_b, m_tvalid, "finished result not presented")

endmodule

>>> src/ccr_front.sv
module ccr_front #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [12*DATA_WIDTH-1:0]                      in_data,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [4*(3*DATA_WIDTH+3)+3*FRAC_BITS+3:0]     out_data
);
    import ccr_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int MW  = 2*W + 1;
    localparam int TW  = 3*W + 2;
    localparam int DW  = 3*W + 3;
    localparam int NW  = DW + FRAC_BITS;
    localparam int NST = 7;

    logic [NST-1:0]         vld_reg;
    logic                   en;

    logic signed [W-1:0]    x_reg   [12];
    logic signed [W-1:0]    el      [4][3][3];
    logic signed [2*W-1:0]  prod_reg  [4][6];
    logic signed [2*W-1:0]  prod_next [4][6];
    logic signed [W-1:0]    r0a_reg [4][3];
    logic signed [W-1:0]    r0b_reg [4][3];
    logic signed [MW-1:0]   mn_reg  [4][3];
    logic signed [MW-1:0]   mn_next [4][3];
    logic signed [MW-1:0]   lo_reg  [4][3];
    logic signed [MW-1:0]   lo_next [4][3];
    logic signed [MW-1:0]   hi_reg  [4][3];
    logic signed [MW-1:0]   hi_next [4][3];
    logic signed [TW-1:0]   tm_reg  [4][3];
    logic signed [TW-1:0]   tm_next [4][3];
    logic signed [DW-1:0]   det_reg [4];
    logic signed [DW-1:0]   det_next [4];
    logic signed [NW-1:0]   num     [3];
    logic [DW-1:0]          dmag_reg;
    logic [DW-1:0]          dmag_next;
    logic [NW-1:0]          nmag_reg  [3];
    logic [NW-1:0]          nmag_next [3];
    logic [2:0]             neg_reg;
    logic [2:0]             neg_next;
    logic                   sing_reg;
    logic                   sing_next;

    // The whole pipe advances together unless its last stage is blocked.
    assign en        = !vld_reg[NST-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = vld_reg[NST-1];
    assign out_data  = {sing_reg, neg_reg, nmag_reg[2], nmag_reg[1], nmag_reg[0], dmag_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    // Matrix 0 is A; matrix k replaces column k-1 of A by the right-hand vector.
    always_comb begin
        for (int m = 0; m < 4; m++) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    el[m][r][c] = (m != 0 && c == m - 1) ? x_reg[9+r] : x_reg[3*r+c];
                end
            end
        end
    end

    // Products of the two lower rows, then their 2x2 minors.
    always_comb begin
        for (int m = 0; m < 4; m++) begin
            prod_next[m][0] = el[m][1][1] * el[m][2][2];
            prod_next[m][1] = el[m][1][2] * el[m][2][1];
            prod_next[m][2] = el[m][1][0] * el[m][2][2];
            prod_next[m][3] = el[m][1][2] * el[m][2][0];
            prod_next[m][4] = el[m][1][0] * el[m][2][1];
            prod_next[m][5] = el[m][1][1] * el[m][2][0];
            for (int j = 0; j < 3; j++) begin
                mn_next[m][j] = MW'(prod_reg[m][2*j]) - MW'(prod_reg[m][2*j+1]);
            end
        end
    end

    // Minor times top-row element in low and high parts, summed to determinants.
    always_comb begin
        for (int m = 0; m < 4; m++) begin
            for (int j = 0; j < 3; j++) begin
                lo_next[m][j] = $signed({1'b0, mn_reg[m][j][W-1:0]}) * r0b_reg[m][j];
                hi_next[m][j] = $signed(mn_reg[m][j][MW-1:W]) * r0b_reg[m][j];
                tm_next[m][j] = (TW'(hi_reg[m][j]) <<< W) + TW'(lo_reg[m][j]);
            end
            det_next[m] = DW'(tm_reg[m][0]) - DW'(tm_reg[m][1]) + DW'(tm_reg[m][2]);
        end
    end

    // Signs, magnitudes and the singular flag for the divider.
    always_comb begin
        sing_next = (det_reg[0] == '0);
        dmag_next = det_reg[0][DW-1] ? DW'(-det_reg[0]) : DW'(det_reg[0]);
        for (int k = 0; k < 3; k++) begin
            num[k]       = NW'(det_reg[k+1]) <<< FRAC_BITS;
            nmag_next[k] = det_reg[k+1][DW-1] ? NW'(-num[k]) : NW'(num[k]);
            neg_next[k]  = det_reg[k+1][DW-1] ^ det_reg[0][DW-1];
        end
    end

    // Data stages carry no reset.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 12; i++) begin
                x_reg[i] <= $signed(in_data[i*W +: W]);
            end
            for (int m = 0; m < 4; m++) begin
                for (int j = 0; j < 6; j++) begin
                    prod_reg[m][j] <= prod_next[m][j];
                end
                for (int j = 0; j < 3; j++) begin
                    r0a_reg[m][j] <= el[m][0][j];
                    r0b_reg[m][j] <= r0a_reg[m][j];
                    mn_reg[m][j]  <= mn_next[m][j];
                    lo_reg[m][j]  <= lo_next[m][j];
                    hi_reg[m][j]  <= hi_next[m][j];
                    tm_reg[m][j]  <= tm_next[m][j];
                end
                det_reg[m] <= det_next[m];
            end
            dmag_reg <= dmag_next;
            for (int k = 0; k < 3; k++) begin
                nmag_reg[k] <= nmag_next[k];
            end
            neg_reg  <= neg_next;
            sing_reg <= sing_next;
        end
    end

endmodule

>>> src/ccr_queue.sv
module ccr_queue #(
    parameter int WIDTH = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ccr_pkg::ccr_q_ctrl_t ctrl,
    output ccr_pkg::ccr_q_stat_t stat,
    input  logic [WIDTH-1:0]    wr_data,
    output logic [WIDTH-1:0]    rd_data
);
    import ccr_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW:0] FULL_COUNT = (AW+1)'(QUEUE_DEPTH);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;

    assign stat.full  = (count_reg == FULL_COUNT);
    assign stat.empty = (count_reg == '0);
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (ctrl.push && !ctrl.pop) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.pop && !ctrl.push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (ctrl.push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (ctrl.pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

>>> src/ccr_div.sv
module ccr_div #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic [3*DATA_WIDTH+3+FRAC_BITS-1:0]   nmag_in,
    input  logic [3*DATA_WIDTH+2:0]               dmag_in,
    input  logic                                  neg_in,
    output logic [DATA_WIDTH-1:0]                 value_out,
    output logic                                  sat_out
);
    import ccr_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int QW1 = W + 1;
    localparam int DW  = 3*W + 3;
    localparam int NW  = DW + FRAC_BITS;
    localparam int CW  = NW + W + 2;
    localparam int NS  = W + 2;

    logic [NW-1:0]  rem_reg  [NS];
    logic [NW-1:0]  rem_next [NS];
    logic [QW1-1:0] q_reg    [NS];
    logic [QW1-1:0] q_next   [NS];
    logic [DW-1:0]  dm_reg   [NS];
    logic [NS-1:0]  ng_reg;
    logic [NS-1:0]  ov_reg;
    logic           ov_first;
    logic [CW-1:0]  dsh      [NS];
    logic [NS-1:0]  ge;
    logic [QW1-1:0] lim;
    logic [QW1-1:0] qs;

    // First stage flags a quotient that cannot fit in DATA_WIDTH+1 bits.
    assign ov_first = CW'(nmag_in) >= (CW'(dmag_in) << QW1);

    // One restoring step per stage after the first, most significant quotient bit first.
    always_comb begin
        rem_next[0] = nmag_in;
        q_next[0]   = '0;
        dsh[0]      = '0;
        ge[0]       = 1'b0;
        for (int j = 1; j < NS; j++) begin
            dsh[j]      = CW'(dm_reg[j-1]) << (NS - 1 - j);
            ge[j]       = CW'(rem_reg[j-1]) >= dsh[j];
            rem_next[j] = ge[j] ? rem_reg[j-1] - dsh[j][NW-1:0] : rem_reg[j-1];
            q_next[j]   = q_reg[j-1] | (QW1'(ge[j]) << (NS - 1 - j));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int j = 0; j < NS; j++) begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
            end
            dm_reg[0] <= dmag_in;
            for (int j = 1; j < NS; j++) begin
                dm_reg[j] <= dm_reg[j-1];
            end
            ng_reg <= {ng_reg[NS-2:0], neg_in};
            ov_reg <= {ov_reg[NS-2:0], ov_first};
        end
    end

    // Clip to the signed range, then apply the sign.
    always_comb begin
        lim = ng_reg[NS-1] ? (QW1'(1) << (W - 1)) : (QW1'(1) << (W - 1)) - 1'b1;
        sat_out = ov_reg[NS-1] || (q_reg[NS-1] > lim);
        qs = sat_out ? lim : q_reg[NS-1];
        value_out = ng_reg[NS-1] ? W'(-qs) : W'(qs);
    end

endmodule

>>> test/cramer_checker.sv
module cramer_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [383:0] s_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [103:0] m_tdata,
    output int           fail_count,
    output int           pending,
    output int           singular_seen,
    output int           clipped_seen
);

    // One expected solution transfer.
    typedef struct {
        logic signed [31:0] x0;
        logic signed [31:0] x1;
        logic signed [31:0] x2;
        logic               singular;
        logic               saturated;
    } solution_t;

    solution_t solutions_due[$];

    // Exact 3x3 determinant at a width that cannot overflow.
    function automatic logic signed [127:0] det_exact(input logic signed [127:0] m[9]);
        logic signed [127:0] t0, t1, t2;
        t0 = m[4] * m[8] - m[5] * m[7];
        t1 = m[3] * m[8] - m[5] * m[6];
        t2 = m[3] * m[7] - m[4] * m[6];
        return m[0] * t0 - m[1] * t1 + m[2] * t2;
    endfunction

    // Works out the solution vector for one system.
    function automatic solution_t solve_system(input logic [383:0] d);
        logic signed [127:0] a[9], m[9];
        logic signed [127:0] det, num, dmag, nmag, q, lim;
        logic                neg;
        logic signed [31:0]  xs[3];
        solution_t           r;
        for (int i = 0; i < 9; i++) a[i] = $signed(d[32*i +: 32]);
        det = det_exact(a);
        r.saturated = 1'b0;
        r.singular = (det == 0);
        if (r.singular) begin
            r.x0 = 0; r.x1 = 0; r.x2 = 0;
            return r;
        end
        dmag = det < 0 ? -det : det;
        for (int k = 0; k < 3; k++) begin
            m = a;
            for (int i = 0; i < 3; i++) m[3*i + k] = $signed(d[32*(9+i) +: 32]);
            num = det_exact(m) <<< 16;
            neg = (num < 0) != (det < 0);
            nmag = num < 0 ? -num : num;
            q = nmag / dmag;
            if (q == 0) neg = 1'b0;
            lim = neg ? 128'sd2147483648 : 128'sd2147483647;
            if (q > lim) begin
                q = lim;
                r.saturated = 1'b1;
            end
            xs[k] = neg ? -q[31:0] : q[31:0];
        end
        r.x0 = xs[0]; r.x1 = xs[1]; r.x2 = xs[2];
        return r;
    endfunction

    assign pending = solutions_due.size();

    // Predict on every input transfer, compare on every output transfer.
    always @(posedge aclk) begin
        solution_t want;
        if (aresetn && s_tvalid && s_tready) solutions_due.push_back(solve_system(s_tdata));
        if (aresetn && m_tvalid && m_tready) begin
            if (solutions_due.size() == 0) begin
                $error("unexpected result transfer %h", m_tdata);
                fail_count++;
            end else begin
                want = solutions_due.pop_front();
                if (want.singular) singular_seen++;
                if (want.saturated) clipped_seen++;
                if (m_tdata[31:0] !== want.x0) begin
                    $error("solution_0: expected %h, got %h", want.x0, m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== want.x1) begin
                    $error("solution_1: expected %h, got %h", want.x1, m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tdata[95:64] !== want.x2) begin
                    $error("solution_2: expected %h, got %h", want.x2, m_tdata[95:64]);
                    fail_count++;
                end
                if (m_tdata[96] !== want.singular) begin
                    $error("singular: expected %b, got %b", want.singular, m_tdata[96]);
                    fail_count++;
                end
                if (m_tdata[97] !== want.saturated) begin
                    $error("saturated: expected %b, got %b", want.saturated, m_tdata[97]);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        fail_count = 0;
        singular_seen = 0;
        clipped_seen = 0;
    end

endmodule

>>> test/tb.sv
module tb;

    localparam int ONE = 32'h0001_0000;
    localparam int LATENCY = 43;
    localparam int IDLE_LIMIT = 20000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [383:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [103:0] m_tdata;
    int           fail_count, pending, singular_seen, clipped_seen;
    int           idle_cycles;
    int           sent;

    solve_3x3_system_cramer_core dut (.*);

    cramer_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int gap_length();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Random element: full range, small values, or one of the extremes.
    function automatic logic [31:0] pick_elem();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3, 4: return $urandom;
            default: return $signed($urandom_range(0, 8*ONE)) - 4*ONE;
        endcase
    endfunction

    // Random system; some have dependent rows so that the determinant vanishes.
    function automatic logic [383:0] random_system();
        logic [383:0] d;
        for (int i = 0; i < 12; i++) d[32*i +: 32] = pick_elem();
        case ($urandom_range(0, 9))
            0: d[32*3 +: 96] = d[0 +: 96];
            1: for (int i = 0; i < 3; i++) d[32*(3*i+2) +: 32] = 0;
            default: ;
        endcase
        return d;
    endfunction

    // Drive one system and hold it until it is taken; a zero gap keeps
    // transfers back to back.
    task automatic send_system(input logic [383:0] d);
        int g;
        g = gap_length();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        do @(posedge aclk); while (!s_tready);
        sent++;
    endtask

    // Receiver stalls at random; with some stretches of no stalling.
    initial begin
        int g;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            g = ($urandom_range(0, 3) == 0) ? 0 : gap_length();
            repeat (g) @(posedge aclk) m_tready <= 1'b0;
            @(posedge aclk) m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    // Watchdog on cycles with no transfer on either channel.
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [383:0] d;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        sent = 0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Identity with simple right-hand side.
        d = '0;
        d[0 +: 32] = ONE; d[128 +: 32] = ONE; d[256 +: 32] = ONE;
        d[288 +: 32] = 3*ONE; d[320 +: 32] = -2*ONE; d[352 +: 32] = ONE/2;
        send_system(d);
        // Zero matrix, singular.
        d = '0;
        d[288 +: 96] = {3{32'h7FFF_FFFF}};
        send_system(d);
        // Tiny diagonal with extreme right-hand side: clipped both ways.
        d = '0;
        d[0 +: 32] = 1; d[128 +: 32] = 1; d[256 +: 32] = 1;
        d[288 +: 32] = 32'h7FFF_FFFF; d[320 +: 32] = 32'h8000_0000; d[352 +: 32] = -1;
        send_system(d);
        // Positive determinant with truncation toward zero.
        d = '0;
        d[0 +: 32] = -3*ONE; d[128 +: 32] = 7*ONE; d[256 +: 32] = -ONE;
        d[288 +: 32] = ONE; d[320 +: 32] = -ONE; d[352 +: 32] = 5;
        send_system(d);
        // All elements at the extremes and all bits of every field toggled.
        send_system({12{32'h8000_0000}});
        send_system({12{32'h7FFF_FFFF}});
        send_system({12{32'hFFFF_FFFF}});
        send_system({12{32'h5555_5555}});
        send_system({12{32'hAAAA_AAAA}});
        d = '0;
        d[0 +: 32] = 32'h8000_0000; d[128 +: 32] = 32'h7FFF_FFFF;
        d[256 +: 32] = 32'h8000_0000; d[288 +: 96] = {3{32'h8000_0000}};
        send_system(d);
        s_tvalid <= 1'b0;

        // Hold off until the block has drained.
        wait (pending == 0);

        repeat (440) send_system(random_system());
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Sent %0d systems; %0d singular and %0d with clipped elements checked.",
                 sent, singular_seen, clipped_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/ccr_pkg.sv
src/ccr_front.sv
src/ccr_queue.sv
src/ccr_div.sv
src/solve_3x3_system_cramer_core.sv
test/cramer_checker.sv
test/tb.sv
